### hw/rtl/lsue_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsue_pkg: shared types and constants for the lane segment unwarp block
// Holds the fixed-point widths, pipeline depths, register indexes, status
// codes and the structs passed between the front end, queue and back end.
// ----------------------------------------------------------------------------
package lsue_pkg;

    // Frame height in rows; the bottom row is reported in Q12.4.
    localparam int FRAME_HEIGHT = 480;
    localparam logic [15:0] BOTTOM_ROW = 16'(FRAME_HEIGHT * 16);

    // Point mapping widths: 32x16 products, sums with one guard bit.
    localparam int PROD_W = 48;
    localparam int SUM_W  = 49;
    localparam int MAG_W  = 48;

    // Denominator constant term: 1.0 at scale 2^-32.
    localparam logic signed [SUM_W-1:0] DEN_ONE = {{(SUM_W-33){1'b0}}, 1'b1, 32'b0};

    // Point quotient divider: one fraction bit per stage.
    localparam int QDIV_STEPS = 16;
    localparam int QDIV_LAT   = QDIV_STEPS + 2;
    // Front end: product, sum and magnitude stages ahead of the dividers.
    localparam int FRONT_LAT  = 3 + QDIV_LAT;

    // Queue between front end and back end.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // Line extension divider: 33-bit dividend, 16-bit divisor.
    localparam int LN_W        = 33;
    localparam int LD_W        = 16;
    localparam int LDIV_STEP   = 3;
    localparam int LDIV_STAGES = LN_W / LDIV_STEP;
    localparam int BACK_LAT    = 4 + LDIV_STAGES;

    // Bottom row as a signed 18-bit operand.
    localparam logic signed [17:0] BOTTOM_S = 18'(FRAME_HEIGHT * 16);

    // Configuration register indexes.
    localparam logic [7:0] CFG_COEF_XX = 8'd0;
    localparam logic [7:0] CFG_COEF_XY = 8'd1;
    localparam logic [7:0] CFG_COEF_XT = 8'd2;
    localparam logic [7:0] CFG_COEF_YX = 8'd3;
    localparam logic [7:0] CFG_COEF_YY = 8'd4;
    localparam logic [7:0] CFG_COEF_YT = 8'd5;
    localparam logic [7:0] CFG_PERSP_X = 8'd6;
    localparam logic [7:0] CFG_PERSP_Y = 8'd7;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DEN = 2'd1,
        ST_HORIZ    = 2'd2,
        ST_SAT      = 2'd3
    } status_t;

    // Homography coefficients.
    typedef struct packed {
        logic signed [31:0] xx;
        logic signed [31:0] xy;
        logic signed [31:0] xt;
        logic signed [31:0] yx;
        logic signed [31:0] yy;
        logic signed [31:0] yt;
        logic signed [31:0] px;
        logic signed [31:0] py;
    } coef_t;

    localparam coef_t COEF_RESET = '{
        xx: 32'sd65536, xy: 32'sd0, xt: 32'sd0,
        yx: 32'sd0, yy: 32'sd65536, yt: 32'sd0,
        px: 32'sd0, py: 32'sd0
    };

    // Mapped segment as queued between front end and back end.
    typedef struct packed {
        logic               zero;
        logic               sat;
        logic signed [15:0] x1;
        logic signed [15:0] y1;
        logic signed [15:0] x2;
        logic signed [15:0] y2;
    } seg_t;

    // Side information carried along the line divider.
    typedef struct packed {
        logic               zero;
        logic               sat;
        logic               horiz;
        logic               neg;
        logic signed [15:0] x1;
        logic signed [15:0] y1;
    } bside_t;

endpackage
`default_nettype wire

### hw/rtl/lsue_qdiv.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsue_qdiv: pipelined Q12.4 quotient of a mapped coordinate
// Restoring division of num * 2^16 by den, one bit per stage, truncated
// toward zero and saturated to 16-bit signed.
// ----------------------------------------------------------------------------
module lsue_qdiv (
    input  wire logic                       clk,
    input  wire logic                       en,
    input  wire logic [lsue_pkg::MAG_W-1:0] num_mag,
    input  wire logic [lsue_pkg::MAG_W-1:0] den_mag,
    input  wire logic                       neg,
    output logic signed [15:0]              quo,
    output logic                            sat
);
    import lsue_pkg::*;

    logic [MAG_W-1:0]      r_reg  [0:QDIV_STEPS-1];
    logic [MAG_W-1:0]      r_next [1:QDIV_STEPS-1];
    logic [MAG_W-1:0]      b_reg  [0:QDIV_STEPS-1];
    logic [QDIV_STEPS-1:0] q_reg  [0:QDIV_STEPS];
    logic [QDIV_STEPS-1:0] q_next [1:QDIV_STEPS];
    logic [QDIV_STEPS:0]   neg_reg;
    logic [QDIV_STEPS:0]   ovf_reg;
    logic signed [15:0]    quo_reg, quo_next;
    logic                  sat_reg, sat_next;

    // One restoring step per stage; the remainder stays below the divisor unless the numerator starts at or above it.
    always_comb
    begin
        logic [MAG_W:0] shifted;
        logic [MAG_W:0] diff;
        logic           ge;
        for (int k = 1; k < QDIV_STEPS; k++)
        begin
            shifted   = {r_reg[k-1], 1'b0};
            diff      = shifted - {1'b0, b_reg[k-1]};
            ge        = (shifted >= {1'b0, b_reg[k-1]});
            r_next[k] = ge ? diff[MAG_W-1:0] : shifted[MAG_W-1:0];
            q_next[k] = {q_reg[k-1][QDIV_STEPS-2:0], ge};
        end
        shifted = {r_reg[QDIV_STEPS-1], 1'b0};
        ge      = (shifted >= {1'b0, b_reg[QDIV_STEPS-1]});
        diff    = '0;
        q_next[QDIV_STEPS] = {q_reg[QDIV_STEPS-1][QDIV_STEPS-2:0], ge};
    end

    // Apply sign and saturate; an integer part forces full scale.
    always_comb
    begin
        logic [QDIV_STEPS:0]          q_mag;
        logic signed [QDIV_STEPS+1:0] sval;
        q_mag = ovf_reg[QDIV_STEPS] ? {1'b1, {QDIV_STEPS{1'b0}}}
                                    : {1'b0, q_reg[QDIV_STEPS]};
        sval  = neg_reg[QDIV_STEPS] ? ((QDIV_STEPS+2)'(0) - $signed({1'b0, q_mag}))
                                    : $signed({1'b0, q_mag});
        if (sval > (QDIV_STEPS+2)'(32767))
        begin
            quo_next = 16'sh7FFF;
            sat_next = 1'b1;
        end
        else if (sval < -(QDIV_STEPS+2)'(32768))
        begin
            quo_next = 16'sh8000;
            sat_next = 1'b1;
        end
        else
        begin
            quo_next = sval[15:0];
            sat_next = 1'b0;
        end
    end

    // Pipeline registers, advanced together with the front end.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]   <= num_mag;
            b_reg[0]   <= den_mag;
            q_reg[0]   <= '0;
            neg_reg[0] <= neg;
            ovf_reg[0] <= (num_mag >= den_mag);
            for (int k = 1; k < QDIV_STEPS; k++)
            begin
                r_reg[k] <= r_next[k];
                b_reg[k] <= b_reg[k-1];
            end
            for (int k = 1; k <= QDIV_STEPS; k++)
            begin
                q_reg[k]   <= q_next[k];
                neg_reg[k] <= neg_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
            end
            quo_reg <= quo_next;
            sat_reg <= sat_next;
        end
    end

    assign quo = quo_reg;
    assign sat = sat_reg;

endmodule
`default_nettype wire

### hw/rtl/lsue_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsue_front: segment intake and homography point mapping
// Forms the projective numerators and denominators of both endpoints and
// divides them in four parallel pipelined dividers.
// ----------------------------------------------------------------------------
module lsue_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire lsue_pkg::coef_t     coef,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic signed [15:0]  start_x,
    input  wire logic signed [15:0]  start_y,
    input  wire logic signed [15:0]  end_x,
    input  wire logic signed [15:0]  end_y,
    output logic                     push,
    output lsue_pkg::seg_t           push_data,
    input  wire logic                queue_full
);
    import lsue_pkg::*;

    function automatic logic [MAG_W-1:0] abs_mag(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] n;
        n = v[SUM_W-1] ? -v : v;
        return n[MAG_W-1:0];
    endfunction

    logic                 front_adv;
    logic [FRONT_LAT-1:0] vld_reg;
    logic [QDIV_LAT-1:0]  zero_line_reg;

    logic signed [PROD_W-1:0] pd_sx_reg, pd_sy_reg, pd_ex_reg, pd_ey_reg;
    logic signed [PROD_W-1:0] px_sx_reg, px_sy_reg, px_ex_reg, px_ey_reg;
    logic signed [PROD_W-1:0] py_sx_reg, py_sy_reg, py_ex_reg, py_ey_reg;
    logic signed [SUM_W-1:0]  den_s_reg, den_e_reg;
    logic signed [SUM_W-1:0]  nx_s_reg, ny_s_reg, nx_e_reg, ny_e_reg;
    logic signed [SUM_W-1:0]  xt16, yt16;
    logic [MAG_W-1:0]         dm_s_reg, dm_e_reg;
    logic [MAG_W-1:0]         nxm_s_reg, nym_s_reg, nxm_e_reg, nym_e_reg;
    logic                     nxneg_s_reg, nyneg_s_reg, nxneg_e_reg, nyneg_e_reg;
    logic                     zero_a_reg;
    logic signed [15:0]       x1, y1, x2, y2;
    logic                     sat_x1, sat_y1, sat_x2, sat_y2;

    // The whole front end moves unless its last stage waits on a full queue.
    assign front_adv = !vld_reg[FRONT_LAT-1] || !queue_full;
    assign in_stall  = !front_adv;
    assign push      = vld_reg[FRONT_LAT-1] && !queue_full;

    // Valid tracking along the pipeline; the zero-denominator flag moves with the datapath.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (front_adv)
        begin
            vld_reg <= {vld_reg[FRONT_LAT-2:0], in_valid};
        end
    end

    // Translation terms scaled to the numerator's 2^-20 scale.
    assign xt16 = SUM_W'($signed(coef.xt)) <<< 4;
    assign yt16 = SUM_W'($signed(coef.yt)) <<< 4;

    // Products, sums and magnitudes.
    always_ff @(posedge clk)
    begin
        if (front_adv)
        begin
            pd_sx_reg <= $signed(coef.px) * start_x;
            pd_sy_reg <= $signed(coef.py) * start_y;
            pd_ex_reg <= $signed(coef.px) * end_x;
            pd_ey_reg <= $signed(coef.py) * end_y;
            px_sx_reg <= $signed(coef.xx) * start_x;
            px_sy_reg <= $signed(coef.xy) * start_y;
            px_ex_reg <= $signed(coef.xx) * end_x;
            px_ey_reg <= $signed(coef.xy) * end_y;
            py_sx_reg <= $signed(coef.yx) * start_x;
            py_sy_reg <= $signed(coef.yy) * start_y;
            py_ex_reg <= $signed(coef.yx) * end_x;
            py_ey_reg <= $signed(coef.yy) * end_y;

            den_s_reg <= SUM_W'(pd_sx_reg) + SUM_W'(pd_sy_reg) + DEN_ONE;
            den_e_reg <= SUM_W'(pd_ex_reg) + SUM_W'(pd_ey_reg) + DEN_ONE;
            nx_s_reg  <= SUM_W'(px_sx_reg) + SUM_W'(px_sy_reg) + xt16;
            ny_s_reg  <= SUM_W'(py_sx_reg) + SUM_W'(py_sy_reg) + yt16;
            nx_e_reg  <= SUM_W'(px_ex_reg) + SUM_W'(px_ey_reg) + xt16;
            ny_e_reg  <= SUM_W'(py_ex_reg) + SUM_W'(py_ey_reg) + yt16;

            dm_s_reg    <= abs_mag(den_s_reg);
            dm_e_reg    <= abs_mag(den_e_reg);
            nxm_s_reg   <= abs_mag(nx_s_reg);
            nym_s_reg   <= abs_mag(ny_s_reg);
            nxm_e_reg   <= abs_mag(nx_e_reg);
            nym_e_reg   <= abs_mag(ny_e_reg);
            nxneg_s_reg <= nx_s_reg[SUM_W-1] ^ den_s_reg[SUM_W-1];
            nyneg_s_reg <= ny_s_reg[SUM_W-1] ^ den_s_reg[SUM_W-1];
            nxneg_e_reg <= nx_e_reg[SUM_W-1] ^ den_e_reg[SUM_W-1];
            nyneg_e_reg <= ny_e_reg[SUM_W-1] ^ den_e_reg[SUM_W-1];
            zero_a_reg  <= (den_s_reg == '0) || (den_e_reg == '0);

            zero_line_reg <= {zero_line_reg[QDIV_LAT-2:0], zero_a_reg};
        end
    end

    // Four coordinate dividers running in lockstep.
    lsue_qdiv u_qdiv_x1 (
        .clk     (clk),
        .en      (front_adv),
        .num_mag (nxm_s_reg),
        .den_mag (dm_s_reg),
        .neg     (nxneg_s_reg),
        .quo     (x1),
        .sat     (sat_x1)
    );

    lsue_qdiv u_qdiv_y1 (
        .clk     (clk),
        .en      (front_adv),
        .num_mag (nym_s_reg),
        .den_mag (dm_s_reg),
        .neg     (nyneg_s_reg),
        .quo     (y1),
        .sat     (sat_y1)
    );

    lsue_qdiv u_qdiv_x2 (
        .clk     (clk),
        .en      (front_adv),
        .num_mag (nxm_e_reg),
        .den_mag (dm_e_reg),
        .neg     (nxneg_e_reg),
        .quo     (x2),
        .sat     (sat_x2)
    );

    lsue_qdiv u_qdiv_y2 (
        .clk     (clk),
        .en      (front_adv),
        .num_mag (nym_e_reg),
        .den_mag (dm_e_reg),
        .neg     (nyneg_e_reg),
        .quo     (y2),
        .sat     (sat_y2)
    );

    // Mapped segment handed to the queue.
    always_comb
    begin
        push_data.zero = zero_line_reg[QDIV_LAT-1];
        push_data.sat  = sat_x1 | sat_y1 | sat_x2 | sat_y2;
        push_data.x1   = x1;
        push_data.y1   = y1;
        push_data.x2   = x2;
        push_data.y2   = y2;
    end

endmodule
`default_nettype wire

### hw/rtl/lsue_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsue_queue: short queue of mapped segments
// Decouples the front end from the back end so that each side can stall
// on its own.
// ----------------------------------------------------------------------------
module lsue_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire lsue_pkg::seg_t push_data,
    output logic                full,
    input  wire logic           pop,
    output logic                head_valid,
    output lsue_pkg::seg_t      head_data
);
    import lsue_pkg::*;

    seg_t              mem [0:QUEUE_DEPTH-1];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full       = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem[rd_ptr_reg];

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/lsue_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsue_back: line extension to the bottom row and result output
// Computes (H - y1) * (x2 - x1) / (y2 - y1) + x1 with a pipelined long
// division, resolves status and holds the result in the output register.
// ----------------------------------------------------------------------------
module lsue_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           head_valid,
    input  wire lsue_pkg::seg_t head_data,
    output logic                pop,
    output logic                out_valid,
    input  wire logic           out_stall,
    output logic signed [15:0]  near_x,
    output logic signed [15:0]  near_y,
    output logic signed [15:0]  bottom_x,
    output logic [1:0]          status
);
    import lsue_pkg::*;

    logic                back_adv;
    logic [BACK_LAT-1:0] vld_reg;

    // First stage: differences.
    logic signed [16:0] dx_reg, dy_reg;
    logic signed [17:0] hy_reg;
    logic signed [15:0] x1_b0_reg, y1_b0_reg;
    logic               zero_b0_reg, sat_b0_reg;

    // Second stage: product and divisor magnitude.
    logic signed [34:0] prod_reg;
    logic [LD_W-1:0]    dmag_b1_reg;
    logic               dneg_b1_reg, horiz_b1_reg;
    logic signed [15:0] x1_b1_reg, y1_b1_reg;
    logic               zero_b1_reg, sat_b1_reg;
    logic signed [16:0] dy_abs;
    logic signed [34:0] prod_abs;

    // Divider stages.
    logic [LD_W-1:0] r_reg  [0:LDIV_STAGES-1];
    logic [LD_W-1:0] r_next [1:LDIV_STAGES];
    logic [LN_W-1:0] w_reg  [0:LDIV_STAGES];
    logic [LN_W-1:0] w_next [1:LDIV_STAGES];
    logic [LD_W-1:0] d_reg  [0:LDIV_STAGES-1];
    bside_t          sb_reg [0:LDIV_STAGES];

    // Output register.
    logic signed [15:0] near_x_reg, near_y_reg, bottom_x_reg;
    status_t            status_reg;
    logic signed [15:0] near_x_next, near_y_next, bottom_x_next;
    status_t            status_next;

    // The back end moves whenever the output register is free or taken.
    assign back_adv  = !vld_reg[BACK_LAT-1] || !out_stall;
    assign pop       = head_valid && back_adv;
    assign out_valid = vld_reg[BACK_LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (back_adv)
        begin
            vld_reg <= {vld_reg[BACK_LAT-2:0], pop};
        end
    end

    assign dy_abs   = dy_reg[16] ? -dy_reg : dy_reg;
    assign prod_abs = prod_reg[34] ? -prod_reg : prod_reg;

    // Long division, three quotient bits per stage.
    always_comb
    begin
        logic [LD_W:0]   rr;
        logic [LD_W-1:0] r;
        logic [LN_W-1:0] w;
        for (int j = 1; j <= LDIV_STAGES; j++)
        begin
            r = (j == LDIV_STAGES) ? '0 : '0;
            r = r_reg[j-1];
            w = w_reg[j-1];
            for (int s = 0; s < LDIV_STEP; s++)
            begin
                rr = {r, w[LN_W-1]};
                w  = {w[LN_W-2:0], 1'b0};
                if (rr >= {1'b0, d_reg[j-1]})
                begin
                    rr   = rr - {1'b0, d_reg[j-1]};
                    w[0] = 1'b1;
                end
                r = rr[LD_W-1:0];
            end
            r_next[j] = r;
            w_next[j] = w;
        end
    end

    // Result selection and status priority.
    always_comb
    begin
        bside_t             sb;
        logic signed [34:0] t;
        logic signed [35:0] sum;
        logic               bsat;
        sb  = sb_reg[LDIV_STAGES];
        t   = sb.neg ? (35'sd0 - $signed({2'b00, w_reg[LDIV_STAGES]}))
                     : $signed({2'b00, w_reg[LDIV_STAGES]});
        sum = 36'(t) + 36'(sb.x1);
        if (sum > 36'sd32767)
        begin
            bottom_x_next = 16'sh7FFF;
            bsat          = 1'b1;
        end
        else if (sum < -36'sd32768)
        begin
            bottom_x_next = 16'sh8000;
            bsat          = 1'b1;
        end
        else
        begin
            bottom_x_next = sum[15:0];
            bsat          = 1'b0;
        end
        near_x_next = sb.x1;
        near_y_next = sb.y1;
        if (sb.zero)
        begin
            near_x_next   = '0;
            near_y_next   = '0;
            bottom_x_next = '0;
            status_next   = ST_ZERO_DEN;
        end
        else if (sb.horiz)
        begin
            bottom_x_next = '0;
            status_next   = ST_HORIZ;
        end
        else if (sb.sat || bsat)
        begin
            status_next = ST_SAT;
        end
        else
        begin
            status_next = ST_OK;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (back_adv)
        begin
            dx_reg      <= 17'(head_data.x2) - 17'(head_data.x1);
            dy_reg      <= 17'(head_data.y2) - 17'(head_data.y1);
            hy_reg      <= BOTTOM_S - 18'(head_data.y1);
            x1_b0_reg   <= head_data.x1;
            y1_b0_reg   <= head_data.y1;
            zero_b0_reg <= head_data.zero;
            sat_b0_reg  <= head_data.sat;

            prod_reg     <= hy_reg * dx_reg;
            dmag_b1_reg  <= dy_abs[LD_W-1:0];
            dneg_b1_reg  <= dy_reg[16];
            horiz_b1_reg <= (dy_reg == '0);
            x1_b1_reg    <= x1_b0_reg;
            y1_b1_reg    <= y1_b0_reg;
            zero_b1_reg  <= zero_b0_reg;
            sat_b1_reg   <= sat_b0_reg;

            r_reg[0]        <= '0;
            w_reg[0]        <= prod_abs[LN_W-1:0];
            d_reg[0]        <= dmag_b1_reg;
            sb_reg[0].zero  <= zero_b1_reg;
            sb_reg[0].sat   <= sat_b1_reg;
            sb_reg[0].horiz <= horiz_b1_reg;
            sb_reg[0].neg   <= prod_reg[34] ^ dneg_b1_reg;
            sb_reg[0].x1    <= x1_b1_reg;
            sb_reg[0].y1    <= y1_b1_reg;

            for (int j = 1; j < LDIV_STAGES; j++)
            begin
                r_reg[j] <= r_next[j];
                d_reg[j] <= d_reg[j-1];
            end
            for (int j = 1; j <= LDIV_STAGES; j++)
            begin
                w_reg[j]  <= w_next[j];
                sb_reg[j] <= sb_reg[j-1];
            end

            near_x_reg   <= near_x_next;
            near_y_reg   <= near_y_next;
            bottom_x_reg <= bottom_x_next;
            status_reg   <= status_next;
        end
    end

    assign near_x   = near_x_reg;
    assign near_y   = near_y_reg;
    assign bottom_x = bottom_x_reg;
    assign status   = status_reg;

endmodule
`default_nettype wire

### hw/rtl/lane_segment_unwarp_extend.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lane_segment_unwarp_extend: lane segment homography unwarp and extension
// Maps both endpoints of a bird's-eye lane segment back to the camera frame
// and extends the line through them to the bottom image row.
// ----------------------------------------------------------------------------
//  Channel   Signals                               Direction  Transfer when
//  input     in_valid, in_stall, start/end x/y     in         valid && !stall
//  output    out_valid, out_stall, near/bottom     out        valid && !stall
//  config    cfg_valid, cfg_ready, cfg_index/data  in         valid && ready
//
//  One segment per cycle is accepted while in_stall is low. A segment passes
//  through the point dividers, the queue and then the line divider.
//  Reset clears pipeline valids, the queue and the coefficients to identity.
//  An output stall holds the back end; the four-entry queue then fills and
//  the front end stalls its input only when the queue is full.
// ----------------------------------------------------------------------------
module lane_segment_unwarp_extend (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [7:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [15:0] start_x,
    input  wire logic signed [15:0] start_y,
    input  wire logic signed [15:0] end_x,
    input  wire logic signed [15:0] end_y,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [15:0]      near_x,
    output logic signed [15:0]      near_y,
    output logic signed [15:0]      bottom_x,
    output logic [15:0]             bottom_y,
    output logic [1:0]              status
);
    import lsue_pkg::*;

    coef_t coef_reg;
    logic  push, pop, queue_full, head_valid;
    seg_t  push_data, head_data;

    assign cfg_ready = 1'b1;
    assign bottom_y  = BOTTOM_ROW;

    // Coefficient registers; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= COEF_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_COEF_XX: coef_reg.xx <= cfg_data;
                CFG_COEF_XY: coef_reg.xy <= cfg_data;
                CFG_COEF_XT: coef_reg.xt <= cfg_data;
                CFG_COEF_YX: coef_reg.yx <= cfg_data;
                CFG_COEF_YY: coef_reg.yy <= cfg_data;
                CFG_COEF_YT: coef_reg.yt <= cfg_data;
                CFG_PERSP_X: coef_reg.px <= cfg_data;
                CFG_PERSP_Y: coef_reg.py <= cfg_data;
                default:     coef_reg    <= coef_reg;
            endcase
        end
    end

    lsue_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .coef       (coef_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .push       (push),
        .push_data  (push_data),
        .queue_full (queue_full)
    );

    lsue_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    lsue_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .near_x     (near_x),
        .near_y     (near_y),
        .bottom_x   (bottom_x),
        .status     (status)
    );

endmodule
`default_nettype wire
